// File: hdl/mapd_pkg.sv
// Shared constants, types and helpers of the moving-average peak detector.
package mapd_pkg;

   // Window storage
   localparam int MAX_WINDOW = 256;
   localparam int ADDR_W     = $clog2(MAX_WINDOW);
   localparam int WIDTH_W    = $clog2(MAX_WINDOW + 1);

   // Field widths
   localparam int VALUE_W  = 16;
   localparam int TIME_W   = 32;
   localparam int SUM_W    = VALUE_W + ADDR_W;
   localparam int OFFSET_W = 24;
   localparam int FRAC_W   = 8;
   localparam int DIFF_W   = VALUE_W + FRAC_W + 2;
   localparam int PROD_W   = DIFF_W + WIDTH_W + 1;
   localparam int BEST_W   = VALUE_W + 1;

   // Configuration port
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 24;
   localparam int CFG_WIDTH_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_WIDTH     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD_OFFSET = CSR_INDEX_W'(1);
   localparam logic [CFG_WIDTH_W-1:0] WINDOW_WIDTH_RESET   = CFG_WIDTH_W'(30);

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OLD,
      ST_READ,
      ST_TEST,
      ST_CMP
   } state_type;

   // Window memory access for one cycle
   typedef struct packed {
      logic               we;
      logic [ADDR_W-1:0]  waddr;
      logic [VALUE_W-1:0] wvalue;
      logic [TIME_W-1:0]  wtime;
      logic               re;
      logic [ADDR_W-1:0]  raddr;
   } mem_req_type;

   // Clamp a written width to 1..MAX_WINDOW
   function automatic logic [WIDTH_W-1:0] eff_width(input logic [CFG_WIDTH_W-1:0] raw);
      logic [WIDTH_W-1:0] w;
      w = WIDTH_W'(1);
      if (int'(raw) > MAX_WINDOW) begin
         w = WIDTH_W'(MAX_WINDOW);
      end else if (raw != '0) begin
         w = WIDTH_W'(raw);
      end
      return w;
   endfunction

endpackage

// File: hdl/mapd_if.sv
// Valid/ready channels for samples and detected peaks.
interface mapd_req_if;
   import mapd_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] sample_value;
   logic [TIME_W-1:0]  sample_time;

   modport source (output valid, output sample_value, output sample_time, input ready);
   modport sink   (input valid, input sample_value, input sample_time, output ready);
endinterface

interface mapd_rsp_if;
   import mapd_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] peak_value;
   logic [TIME_W-1:0]  peak_time;

   modport source (output valid, output peak_value, output peak_time, input ready);
   modport sink   (input valid, input peak_value, input peak_time, output ready);
endinterface

// File: hdl/mapd_window_mem.sv
// Circular sample store: value and timestamp memories, one write and one read port.
module mapd_window_mem
   import mapd_pkg::*;
(
   input  logic               clock,
   input  mem_req_type        mem_req,
   output logic [VALUE_W-1:0] rd_value,
   output logic [TIME_W-1:0]  rd_time
);

   logic [VALUE_W-1:0] value_mem [MAX_WINDOW];
   logic [TIME_W-1:0]  time_mem  [MAX_WINDOW];
   logic [VALUE_W-1:0] rd_value_ff;
   logic [TIME_W-1:0]  rd_time_ff;

   // Write the new sample
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         value_mem[mem_req.waddr] <= mem_req.wvalue;
         time_mem[mem_req.waddr]  <= mem_req.wtime;
      end
   end

   // Registered read, held until the next read
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_value_ff <= value_mem[mem_req.raddr];
         rd_time_ff  <= time_mem[mem_req.raddr];
      end
   end

   assign rd_value = rd_value_ff;
   assign rd_time  = rd_time_ff;

endmodule

// File: hdl/mapd_thresh.sv
// Exact threshold test: (v*256 - offset) * width >= sum * 256, product registered.
module mapd_thresh
   import mapd_pkg::*;
(
   input  logic                       clock,
   input  logic [VALUE_W-1:0]         test_value,
   input  logic signed [OFFSET_W-1:0] offset,
   input  logic [WIDTH_W-1:0]         width,
   input  logic [SUM_W-1:0]           sum,
   output logic                       at_or_above
);

   logic signed [DIFF_W-1:0]  diff;
   logic signed [PROD_W-1:0]  product_in;
   logic signed [PROD_W-1:0]  product_ff;
   logic signed [PROD_W-1:0]  rhs_in;
   logic signed [PROD_W-1:0]  rhs_ff;

   // Scale the sample and remove the offset, then weight by the width
   always_comb begin
      diff = $signed({2'b00, test_value, {FRAC_W{1'b0}}})
           - DIFF_W'(offset);
      product_in = PROD_W'(diff * $signed({1'b0, width}));
      rhs_in     = $signed(PROD_W'({sum, {FRAC_W{1'b0}}}));
   end

   // Register both sides of the compare
   always_ff @(posedge clock) begin
      product_ff <= product_in;
      rhs_ff     <= rhs_in;
   end

   assign at_or_above = (product_ff >= rhs_ff);

endmodule

// File: hdl/moving_average_peak_detector.sv
// Top level: sequencer, window bookkeeping, peak tracker and result register.
//
//   channel   dir   handshake        payload
//   req_chan  in    valid/ready      sample_value[15:0], sample_time[31:0]
//   rsp_chan  out   valid/ready      peak_value[15:0], peak_time[31:0]
//   csr_*     in    csr_we           csr_index[1:0], csr_wdata[23:0]
//
// A sample goes through idle and old while the window fills, and through read,
// test and compare too once it is full: the window memory's single read port is
// used twice in series (evicted sample, then oldest sample) and the threshold
// product is registered. Reset is synchronous; the memories need no clearing
// pass after it. The result register lets the next transaction start while a
// peak waits; a second peak waits in the compare step until the first is taken.
module moving_average_peak_detector
   import mapd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   mapd_req_if.sink               req_chan,
   mapd_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   state_type                  state_ff, state_in;
   logic [VALUE_W-1:0]         value_ff, value_in;
   logic [TIME_W-1:0]          time_ff, time_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [WIDTH_W-1:0]         fill_ff, fill_in;
   logic [ADDR_W-1:0]          slot_ff, slot_in;
   logic                       in_exc_ff, in_exc_in;
   logic signed [BEST_W-1:0]   best_value_ff, best_value_in;
   logic [TIME_W-1:0]          best_time_ff, best_time_in;
   logic [WIDTH_W-1:0]         win_w_ff, win_w_in;
   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]         rsp_value_ff, rsp_value_in;
   logic [TIME_W-1:0]          rsp_time_ff, rsp_time_in;

   mem_req_type        mem_req;
   logic [VALUE_W-1:0] rd_value;
   logic [TIME_W-1:0]  rd_time;
   logic               at_or_above;
   logic               full_now;
   logic [WIDTH_W-1:0] slot_inc;
   logic [WIDTH_W-1:0] fill_inc;
   logic               rsp_load;

   mapd_window_mem u_mem (
      .clock    (clock),
      .mem_req  (mem_req),
      .rd_value (rd_value),
      .rd_time  (rd_time)
   );

   mapd_thresh u_thresh (
      .clock       (clock),
      .test_value  (rd_value),
      .offset      (offset_ff),
      .width       (win_w_ff),
      .sum         (sum_ff),
      .at_or_above (at_or_above)
   );

   assign full_now = (fill_ff >= win_w_ff);
   assign slot_inc = WIDTH_W'(slot_ff) + WIDTH_W'(1);
   assign fill_inc = fill_ff + WIDTH_W'(1);

   // Next state, window bookkeeping and peak tracking
   always_comb begin
      state_in      = state_ff;
      value_in      = value_ff;
      time_in       = time_ff;
      sum_in        = sum_ff;
      fill_in       = fill_ff;
      slot_in       = slot_ff;
      in_exc_in     = in_exc_ff;
      best_value_in = best_value_ff;
      best_time_in  = best_time_ff;
      win_w_in      = win_w_ff;
      offset_in     = offset_ff;
      rsp_load      = 1'b0;
      mem_req       = '{we: 1'b0, waddr: slot_ff, wvalue: value_ff, wtime: time_ff,
                        re: 1'b0, raddr: slot_ff};
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               value_in   = req_chan.sample_value;
               time_in    = req_chan.sample_time;
               mem_req.re = 1'b1;
               state_in   = ST_OLD;
            end
         end
         ST_OLD: begin
            // Evict the oldest sample once full, store the new one, advance
            mem_req.we = 1'b1;
            sum_in = sum_ff - (full_now ? SUM_W'(rd_value) : SUM_W'(0))
                   + SUM_W'(value_ff);
            if (!full_now) begin
               fill_in = fill_inc;
            end
            slot_in  = (slot_inc >= win_w_ff) ? '0 : ADDR_W'(slot_inc);
            state_in = (full_now || fill_inc >= win_w_ff) ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            mem_req.re = 1'b1;
            state_in   = ST_TEST;
         end
         ST_TEST: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (at_or_above) begin
               if ($signed({1'b0, rd_value}) > best_value_ff) begin
                  best_value_in = $signed({1'b0, rd_value});
                  best_time_in  = rd_time;
               end
               in_exc_in = 1'b1;
               state_in  = ST_IDLE;
            end else if (!in_exc_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_chan.ready) begin
               // Emit the finished peak and clear the tracker
               rsp_load      = 1'b1;
               in_exc_in     = 1'b0;
               best_value_in = '1;
               best_time_in  = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The user must send configuration writes only while idle; the block does not enforce it
      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_WIDTH: begin
               win_w_in      = eff_width(csr_wdata[CFG_WIDTH_W-1:0]);
               sum_in        = '0;
               fill_in       = '0;
               slot_in       = '0;
               in_exc_in     = 1'b0;
               best_value_in = '1;
               best_time_in  = '0;
            end
            CSR_THRESHOLD_OFFSET: begin
               offset_in = $signed(csr_wdata[OFFSET_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_time_in  = rsp_time_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = best_value_ff[VALUE_W-1:0];
         rsp_time_in  = best_time_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sum_ff        <= '0;
         fill_ff       <= '0;
         slot_ff       <= '0;
         in_exc_ff     <= 1'b0;
         best_value_ff <= '1;
         best_time_ff  <= '0;
         win_w_ff      <= eff_width(WINDOW_WIDTH_RESET);
         offset_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sum_ff        <= sum_in;
         fill_ff       <= fill_in;
         slot_ff       <= slot_in;
         in_exc_ff     <= in_exc_in;
         best_value_ff <= best_value_in;
         best_time_ff  <= best_time_in;
         win_w_ff      <= win_w_in;
         offset_ff     <= offset_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      time_ff      <= time_in;
      rsp_value_ff <= rsp_value_in;
      rsp_time_ff  <= rsp_time_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.peak_value = rsp_value_ff;
   assign rsp_chan.peak_time  = rsp_time_ff;

   // Fill count never passes the window width
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= win_w_ff)
      else $error("fill count beyond window width");

   // Write slot stays inside the window
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      WIDTH_W'(slot_ff) < win_w_ff)
      else $error("write slot outside window");

   // Tracker holds -1 whenever no excursion is open
   a_tracker_clear: assert property (@(posedge clock) disable iff (reset)
      !in_exc_ff |-> (best_value_ff == '1))
      else $error("peak tracker not cleared outside excursion");

   // An emitted peak closes the excursion and shows on the result channel
   a_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && !in_exc_ff))
      else $error("emitted peak not presented");

endmodule
